// File: rtl/core/direct_color_pixel_write_top_assert.svh
// assertion macros for the direct-color pixel write block
// used by the port-level checker; needs nothing but a clock named clk and reset rst_n
`ifndef DIRECT_COLOR_PIXEL_WRITE_TOP_ASSERT_SVH
`define DIRECT_COLOR_PIXEL_WRITE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DCPW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay in cycles, checked outside reset
`define DCPW_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dcpw_pkg.sv
// shared types and constants of the direct-color pixel write block
// no dependencies; used by the top level and the checker
package dcpw_pkg;

  // register reset values
  localparam logic [15:0] XRES_RST  = 16'd1024;
  localparam logic [15:0] YRES_RST  = 16'd768;
  localparam logic [5:0]  BPP_RST   = 6'd32;
  localparam logic [11:0] SIZES_RST = 12'h888;
  localparam logic [14:0] POS_RST   = 15'h4108;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // latency from accepted request to result strobe
  localparam int LATENCY = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_XRES  = 3'd0,
    CFG_YRES  = 3'd1,
    CFG_BPP   = 3'd2,
    CFG_SIZES = 3'd3,
    CFG_POS   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] rgb_color;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [33:0] byte_offset;
    logic [31:0] pixel_data;
    logic [2:0]  byte_count;
  } out_t;

endpackage

// File: rtl/core/dcpw_chan.sv
// two-stage color channel scaler: (2^size-1)*c/255, truncated
// depends on nothing; instantiated once per channel by the top level
module dcpw_chan (
  input  logic       clk,
  input  logic [7:0] chan_in,
  input  logic [3:0] size,
  output logic [7:0] scaled_out
);

  logic [3:0]  size_clip;
  logic [8:0]  mask_wide;
  logic [7:0]  mask;
  logic [15:0] prod_r;
  logic [15:0] prod_nxt;
  logic [16:0] quot_sum;
  logic [7:0]  scaled_r;

  // sizes above 8 behave as 8
  always_comb begin
    size_clip = (size > 4'd8) ? 4'd8 : size;
    mask_wide = (9'd1 << size_clip) - 9'd1;
    mask      = mask_wide[7:0];
    prod_nxt  = 16'(mask) * 16'(chan_in);
  end

  // floor(v/255) for v below 2^16: (v + 1 + v/256) / 256
  always_comb begin
    quot_sum = 17'(prod_r) + 17'd1 + 17'(prod_r[15:8]);
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    scaled_r <= quot_sum[15:8];
  end

  assign scaled_out = scaled_r;

endmodule

// File: rtl/core/direct_color_pixel_write_top.sv
// top level of the direct-color pixel write block
// depends on dcpw_pkg and dcpw_chan
//
// One pixel write request (x, y, rgb color) is taken at every clock edge where start is
// high and busy is low; busy is high only in reset and the cycle after it, so requests
// stream at one per cycle. Each request yields exactly one result, shown on out_result
// for a single cycle with out_strobe high. The receiver cannot stall the block and
// results are not held, so the receiver must take every strobed result as it comes.
// A pixel outside the configured resolution gives write_enable low and all other result
// fields zero. The three register stages are: y*x_resolution and the
// channel multiplies, then the row add and the divide by 255, then field placement and
// the byte-count scaling of the offset. Registers are written through cfg_we/cfg_index/
// cfg_wdata and take effect at once; write them only while no request is in flight.
module direct_color_pixel_write_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  dcpw_pkg::in_t                       in_req,
  // result channel
  output logic                                out_strobe,
  output dcpw_pkg::out_t                      out_result,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [dcpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcpw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [15:0] xres_r;
  logic [15:0] yres_r;
  logic [5:0]  bpp_r;
  logic [11:0] sizes_r;
  logic [14:0] pos_r;

  logic busy_r;
  logic accept;

  // stage 1 signals
  logic        in_range;
  logic [6:0]  bpp_round;
  logic [2:0]  bytes_nxt;
  logic        v1_r;
  logic        inr1_r;
  logic [15:0] x1_r;
  logic [31:0] yx1_r;
  logic [2:0]  bytes1_r;
  logic [7:0]  idx1_r;

  // stage 2 signals
  logic        v2_r;
  logic        inr2_r;
  logic [32:0] sum2_r;
  logic [2:0]  bytes2_r;
  logic [7:0]  idx2_r;

  // scaled channels, aligned with stage 2
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  // stage 3 (output) signals
  logic [31:0]    packed_data;
  logic [31:0]    pixel_data;
  logic [33:0]    offset;
  logic [33:0]    sum_ext;
  dcpw_pkg::out_t result_nxt;
  logic           strobe_r;
  dcpw_pkg::out_t result_r;

  // busy only in reset and right after it
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xres_r  <= dcpw_pkg::XRES_RST;
      yres_r  <= dcpw_pkg::YRES_RST;
      bpp_r   <= dcpw_pkg::BPP_RST;
      sizes_r <= dcpw_pkg::SIZES_RST;
      pos_r   <= dcpw_pkg::POS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcpw_pkg::CFG_XRES:  xres_r  <= cfg_wdata[15:0];
        dcpw_pkg::CFG_YRES:  yres_r  <= cfg_wdata[15:0];
        dcpw_pkg::CFG_BPP:   bpp_r   <= cfg_wdata[5:0];
        dcpw_pkg::CFG_SIZES: sizes_r <= cfg_wdata[11:0];
        dcpw_pkg::CFG_POS:   pos_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // stage 1: bounds check, bytes per pixel, row multiply
  always_comb begin
    in_range  = (in_req.pixel_x < xres_r) && (in_req.pixel_y < yres_r);
    bpp_round = (7'(bpp_r) + 7'd7) >> 3;
    // depth zero counts as one byte, anything past four bytes as four
    if (bpp_round == 7'd0) begin
      bytes_nxt = 3'd1;
    end else if (bpp_round > 7'd4) begin
      bytes_nxt = 3'd4;
    end else begin
      bytes_nxt = bpp_round[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    inr1_r   <= in_range;
    x1_r     <= in_req.pixel_x;
    yx1_r    <= 32'(in_req.pixel_y) * 32'(xres_r);
    bytes1_r <= bytes_nxt;
    idx1_r   <= in_req.rgb_color[7:0];
  end

  // per-channel scalers: multiply in stage 1, divide by 255 in stage 2
  dcpw_chan u_red (
    .clk        (clk),
    .chan_in    (in_req.rgb_color[23:16]),
    .size       (sizes_r[11:8]),
    .scaled_out (red_q)
  );

  dcpw_chan u_green (
    .clk        (clk),
    .chan_in    (in_req.rgb_color[15:8]),
    .size       (sizes_r[7:4]),
    .scaled_out (green_q)
  );

  dcpw_chan u_blue (
    .clk        (clk),
    .chan_in    (in_req.rgb_color[7:0]),
    .size       (sizes_r[3:0]),
    .scaled_out (blue_q)
  );

  // stage 2: pixel index x + y*xres
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    inr2_r   <= inr1_r;
    sum2_r   <= 33'(x1_r) + 33'(yx1_r);
    bytes2_r <= bytes1_r;
    idx2_r   <= idx1_r;
  end

  // stage 3: field placement, byte masking, offset scaling
  always_comb begin
    // bits shifted past bit 31 fall off
    packed_data = (32'(red_q) << pos_r[14:10])
                | (32'(green_q) << pos_r[9:5])
                | (32'(blue_q) << pos_r[4:0]);

    case (bytes2_r)
      3'd1:    pixel_data = 32'(idx2_r);
      3'd2:    pixel_data = packed_data & 32'h0000_ffff;
      3'd3:    pixel_data = packed_data & 32'h00ff_ffff;
      default: pixel_data = packed_data;
    endcase

    sum_ext = 34'(sum2_r);
    case (bytes2_r)
      3'd1:    offset = sum_ext;
      3'd2:    offset = sum_ext << 1;
      3'd3:    offset = sum_ext + (sum_ext << 1);
      default: offset = sum_ext << 2;
    endcase

    // suppressed writes report all zeros
    if (inr2_r) begin
      result_nxt.write_enable = 1'b1;
      result_nxt.byte_offset  = offset;
      result_nxt.pixel_data   = pixel_data;
      result_nxt.byte_count   = bytes2_r;
    end else begin
      result_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule

// File: rtl/core/dcpw_checker.sv
// port-level checker for the direct-color pixel write block, bound to the top level
// depends on dcpw_pkg and the macros in direct_color_pixel_write_top_assert.svh
`include "direct_color_pixel_write_top_assert.svh"

module dcpw_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input dcpw_pkg::out_t out_result
);

  logic req_acc;
  logic wr_strobe;
  logic skip_strobe;
  logic fields_zero;
  logic count_ok;

  assign req_acc     = start && !busy;
  assign wr_strobe   = out_strobe && out_result.write_enable;
  assign skip_strobe = out_strobe && !out_result.write_enable;
  assign fields_zero = (out_result.byte_offset == 34'd0)
                    && (out_result.pixel_data == 32'd0)
                    && (out_result.byte_count == 3'd0);
  // one to four bytes, data bits above the written bytes are clear
  assign count_ok    = ((out_result.byte_count == 3'd1) && (out_result.pixel_data[31:8] == 24'd0))
                    || ((out_result.byte_count == 3'd2) && (out_result.pixel_data[31:16] == 16'd0))
                    || ((out_result.byte_count == 3'd3) && (out_result.pixel_data[31:24] == 8'd0))
                    || (out_result.byte_count == 3'd4);

  // every accepted request is followed by one result strobe
  `DCPW_ASSERT_DLY(a_req_to_result, req_acc, 3, out_strobe, "missing result for request")

  // no result strobe without an earlier accepted request
  `DCPW_ASSERT_IMP(a_no_spurious, out_strobe, $past(req_acc, 3), "result without request")

  // suppressed write reports zeros
  `DCPW_ASSERT_IMP(a_suppress_zero, skip_strobe, fields_zero, "suppressed write not zero")

  // written pixel covers one to four bytes and nothing above them
  `DCPW_ASSERT_IMP(a_count_range, wr_strobe, count_ok, "bad byte count or data")

endmodule

bind direct_color_pixel_write_top dcpw_checker u_dcpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
